/* hdl/bvfg_pkg.sv */
// ----------------------------------------------------------------------------
// bvfg_pkg
// Shared constants, types and helpers of the battery voltage fuel gauge.
// ----------------------------------------------------------------------------
package bvfg_pkg;

  // sizing
  localparam int AVG_DEPTH  = 8;
  localparam int MAX_CURVES = 8;
  localparam int MAX_POINTS = 16;

  // field widths
  localparam int CMD_W  = 2;
  localparam int V_W    = 23;
  localparam int PCT_W  = 7;
  localparam int TIME_W = 20;
  localparam int LOAD_W = 16;
  localparam int CIDX_W = 3;
  localparam int PIDX_W = 4;
  localparam int CCNT_W = 4;
  localparam int PPC_W  = 5;
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 23;

  // derived widths
  localparam int WP_W   = $clog2(AVG_DEPTH);
  localparam int CNT_W  = $clog2(AVG_DEPTH + 1);
  localparam int SUM_W  = V_W + $clog2(AVG_DEPTH);
  localparam int CS_W   = $clog2(MAX_CURVES);
  localparam int PS_W   = $clog2(MAX_POINTS);
  localparam int PT_AW  = $clog2(MAX_CURVES * MAX_POINTS);
  localparam int PT_DW  = V_W + PCT_W + TIME_W;

  // interpolation unit widths
  localparam int IW    = SUM_W;
  localparam int PW    = 2 * IW;
  localparam int RW    = PW + 2;
  localparam int DC_W  = $clog2(PW);

  // limits
  localparam int VMAX     = (1 << V_W) - 1;
  localparam int PCT_MAX  = 100;
  localparam int TIME_MAX = (1 << TIME_W) - 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE   = 2'd0,
    CMD_RST_AVG  = 2'd1,
    CMD_WR_POINT = 2'd2,
    CMD_WR_LOAD  = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IW-1:0] {
    REG_CORR_X_LOW  = 3'd0,
    REG_CORR_Y_LOW  = 3'd1,
    REG_CORR_X_HIGH = 3'd2,
    REG_CORR_Y_HIGH = 3'd3,
    REG_LOAD_CUR    = 3'd4,
    REG_CURVE_CNT   = 3'd5,
    REG_POINTS      = 3'd6
  } cfg_reg_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_TAKE, OP_AVG_GO, OP_AVG_END, OP_COR_GO, OP_COR_END,
    OP_EST_INIT, OP_CS_RD, OP_CS_CMP, OP_PS_INIT, OP_PS_RD, OP_PS_CMP,
    OP_PE_GO, OP_PE_END, OP_FI_GO, OP_FI_END, OP_HOLD_PCT, OP_HOLD_TIME,
    OP_OUT
  } dp_op_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_AVG_GO, ST_AVG_WT, ST_COR_GO, ST_COR_WT, ST_EST,
    ST_CS_RD, ST_CS_CMP, ST_PS_INIT, ST_PS_RD, ST_PS_CMP, ST_PE_GO,
    ST_PE_WT, ST_FI_GO, ST_FI_WT, ST_CHK, ST_DONE
  } ctrl_state_e;

  typedef enum logic [1:0] {
    IP_IDLE, IP_MUL, IP_DIV, IP_FIN
  } ip_phase_e;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [V_W-1:0]    sample_uv;
    logic [CIDX_W-1:0] curve_index;
    logic [PIDX_W-1:0] point_index;
    logic [V_W-1:0]    point_voltage_uv;
    logic [PCT_W-1:0]  point_capacity;
    logic [TIME_W-1:0] point_time_s;
    logic [LOAD_W-1:0] curve_load;
  } in_item_t;

  typedef struct packed {
    logic [PCT_W-1:0]  capacity_percent;
    logic [TIME_W-1:0] remaining_time_s;
    logic              estimate_changed;
    logic              window_full;
  } out_item_t;

  typedef struct packed {
    logic [IW-1:0] x0;
    logic [IW-1:0] x1;
    logic [IW-1:0] y1;
    logic [IW-1:0] x2;
    logic [IW-1:0] y2;
  } ip_args_t;

  typedef struct packed {
    logic is_sample;
    logic ar_done;
    logic cs_stop;
    logic ps_stop;
    logic more_curves;
    logic want_time;
    logic pct_differs;
    logic out_free;
  } dp_status_t;

  // clamp a signed result into 0..hi
  function automatic logic [IW-1:0] sat_res(input logic signed [RW-1:0] v,
                                            input logic [IW-1:0] hi);
    if (v < 0) return '0;
    else if (v > $signed({{(RW-IW){1'b0}}, hi})) return hi;
    else return v[IW-1:0];
  endfunction

endpackage

/* hdl/bvfg_if.sv */
// ----------------------------------------------------------------------------
// bvfg_in_if / bvfg_out_if
// Valid/ready channels carrying command items in and estimates out.
// ----------------------------------------------------------------------------
interface bvfg_in_if;
  logic                          valid;
  logic                          ready;
  logic [bvfg_pkg::CMD_W-1:0]    cmd;
  logic [bvfg_pkg::V_W-1:0]      sample_uv;
  logic [bvfg_pkg::CIDX_W-1:0]   curve_index;
  logic [bvfg_pkg::PIDX_W-1:0]   point_index;
  logic [bvfg_pkg::V_W-1:0]      point_voltage_uv;
  logic [bvfg_pkg::PCT_W-1:0]    point_capacity;
  logic [bvfg_pkg::TIME_W-1:0]   point_time_s;
  logic [bvfg_pkg::LOAD_W-1:0]   curve_load;

  modport source (output valid, cmd, sample_uv, curve_index, point_index,
                  point_voltage_uv, point_capacity, point_time_s, curve_load,
                  input ready);
  modport sink (input valid, cmd, sample_uv, curve_index, point_index,
                point_voltage_uv, point_capacity, point_time_s, curve_load,
                output ready);
endinterface

interface bvfg_out_if;
  logic                          valid;
  logic                          ready;
  logic [bvfg_pkg::PCT_W-1:0]    capacity_percent;
  logic [bvfg_pkg::TIME_W-1:0]   remaining_time_s;
  logic                          estimate_changed;
  logic                          window_full;

  modport source (output valid, capacity_percent, remaining_time_s,
                  estimate_changed, window_full, input ready);
  modport sink (input valid, capacity_percent, remaining_time_s,
                estimate_changed, window_full, output ready);
endinterface

/* hdl/bvfg_ram.sv */
// ----------------------------------------------------------------------------
// bvfg_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bvfg_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] addr_i,
  input  logic [W-1:0]         wdata_i,
  output logic [W-1:0]         rdata_o
);
  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;
endmodule

/* hdl/bvfg_interp.sv */
// ----------------------------------------------------------------------------
// bvfg_interp
// Linear interpolation unit: y1 + (x0-x1)*(y2-y1)/(x2-x1), quotient truncated
// toward zero, one multiply then a restoring divide of one bit per cycle.
// ----------------------------------------------------------------------------
module bvfg_interp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  bvfg_pkg::ip_args_t                args_i,
  output logic                              done_o,
  output logic signed [bvfg_pkg::RW-1:0]    res_o
);
  bvfg_pkg::ip_phase_e ph_q;
  logic [bvfg_pkg::DC_W-1:0] cnt_q;
  logic [bvfg_pkg::IW-1:0]   ax_q, ay_q, ad_q, y1_q, rem_q, rem_n;
  logic [bvfg_pkg::PW-1:0]   num_q;
  logic                      neg_q, eq_q, ge;
  logic [bvfg_pkg::IW:0]     dx, dy, dd, t;
  logic [bvfg_pkg::RW-1:0]   y1e, qe;

  // operand differences
  assign dx = {1'b0, args_i.x0} - {1'b0, args_i.x1};
  assign dy = {1'b0, args_i.y2} - {1'b0, args_i.y1};
  assign dd = {1'b0, args_i.x2} - {1'b0, args_i.x1};

  // one restoring divide step
  assign t     = {rem_q, num_q[bvfg_pkg::PW-1]};
  assign ge    = t >= {1'b0, ad_q};
  assign rem_n = ge ? bvfg_pkg::IW'(t - {1'b0, ad_q}) : t[bvfg_pkg::IW-1:0];

  // phase sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= bvfg_pkg::IP_IDLE;
      cnt_q <= '0;
    end else begin
      unique case (ph_q)
        bvfg_pkg::IP_IDLE: if (start_i) ph_q <= bvfg_pkg::IP_MUL;
        bvfg_pkg::IP_MUL: begin
          ph_q  <= bvfg_pkg::IP_DIV;
          cnt_q <= '0;
        end
        bvfg_pkg::IP_DIV: begin
          if (cnt_q == bvfg_pkg::DC_W'(bvfg_pkg::PW - 1)) ph_q <= bvfg_pkg::IP_FIN;
          else cnt_q <= cnt_q + 1'b1;
        end
        bvfg_pkg::IP_FIN: ph_q <= bvfg_pkg::IP_IDLE;
        default: ph_q <= bvfg_pkg::IP_IDLE;
      endcase
    end
  end

  // operand, product and quotient registers
  always_ff @(posedge clk_i) begin
    if (start_i && ph_q == bvfg_pkg::IP_IDLE) begin
      ax_q  <= dx[bvfg_pkg::IW] ? bvfg_pkg::IW'(-dx) : dx[bvfg_pkg::IW-1:0];
      ay_q  <= dy[bvfg_pkg::IW] ? bvfg_pkg::IW'(-dy) : dy[bvfg_pkg::IW-1:0];
      ad_q  <= dd[bvfg_pkg::IW] ? bvfg_pkg::IW'(-dd) : dd[bvfg_pkg::IW-1:0];
      neg_q <= dx[bvfg_pkg::IW] ^ dy[bvfg_pkg::IW] ^ dd[bvfg_pkg::IW];
      eq_q  <= args_i.x1 == args_i.x2;
      y1_q  <= args_i.y1;
    end
    if (ph_q == bvfg_pkg::IP_MUL) begin
      num_q <= ax_q * ay_q;
      rem_q <= '0;
    end
    if (ph_q == bvfg_pkg::IP_DIV) begin
      num_q <= {num_q[bvfg_pkg::PW-2:0], ge};
      rem_q <= rem_n;
    end
  end

  // result
  assign y1e    = bvfg_pkg::RW'(y1_q);
  assign qe     = bvfg_pkg::RW'(num_q);
  assign res_o  = eq_q ? $signed(y1e) : (neg_q ? $signed(y1e - qe) : $signed(y1e + qe));
  assign done_o = ph_q == bvfg_pkg::IP_FIN;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ph_q == bvfg_pkg::IP_IDLE)
    else $error("interpolation started while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done held longer than one cycle");
endmodule

/* hdl/bvfg_dp.sv */
// ----------------------------------------------------------------------------
// bvfg_dp
// Datapath: configuration, averaging ring, curve tables, scan registers,
// interpolation unit and output register.
// ----------------------------------------------------------------------------
module bvfg_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bvfg_pkg::dp_op_e              op_i,
  input  bvfg_pkg::in_item_t            item_i,
  input  logic                          cfg_we_i,
  input  logic [bvfg_pkg::CFG_IW-1:0]   cfg_idx_i,
  input  logic [bvfg_pkg::CFG_DW-1:0]   cfg_data_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output bvfg_pkg::out_item_t           out_item_o,
  output bvfg_pkg::dp_status_t          st_o
);
  // configuration
  logic [bvfg_pkg::V_W-1:0]    cxl_q, cyl_q, cxh_q, cyh_q;
  logic [bvfg_pkg::LOAD_W-1:0] load_q;
  logic [bvfg_pkg::CCNT_W-1:0] ccnt_q, ncur, ncur_m1;
  logic [bvfg_pkg::PPC_W-1:0]  ppc_q, npts, npts_m1;

  // averaging
  logic [bvfg_pkg::V_W-1:0]   ring_q [bvfg_pkg::AVG_DEPTH];
  logic [bvfg_pkg::WP_W-1:0]  wp_q;
  logic                       wrapped_q, wp_last;
  logic [bvfg_pkg::SUM_W-1:0] sum_q, sum_new;
  logic [bvfg_pkg::CNT_W-1:0] cnt;
  logic [bvfg_pkg::V_W-1:0]   avg_q, v_q;

  // scans
  logic [bvfg_pkg::CS_W-1:0]   cidx_q, k1_q, k2_q, ck;
  logic [bvfg_pkg::LOAD_W-1:0] l1_q, l2_q, prevl_q, ld;
  logic [bvfg_pkg::PS_W-1:0]   pidx_q;
  logic [bvfg_pkg::V_W-1:0]    v1_q, v2_q, prevv_q, pv;
  logic [bvfg_pkg::TIME_W-1:0] c1_q, c2_q, prevc_q, pval;
  logic [bvfg_pkg::TIME_W-1:0] r1_q, r2_q, est_q;
  logic                        pass_q, want_q, changed_q;
  logic                        cs_found, cs_last, ps_found, ps_last;

  // held estimates and output
  logic [bvfg_pkg::PCT_W-1:0]  held_pct_q;
  logic [bvfg_pkg::TIME_W-1:0] held_time_q;
  logic                        out_valid_q, out_free;
  bvfg_pkg::out_item_t         out_q;

  // tables
  logic                        take, is_sample;
  logic                        ld_we, pt_we;
  logic [bvfg_pkg::CS_W-1:0]   ld_addr;
  logic [bvfg_pkg::PT_AW-1:0]  pt_addr, pt_waddr, pt_raddr;
  logic [bvfg_pkg::PT_DW-1:0]  pt_rd;
  logic [bvfg_pkg::LOAD_W-1:0] ld_rd;

  // interpolation
  bvfg_pkg::ip_args_t              args;
  logic                            ip_start, ip_done;
  logic signed [bvfg_pkg::RW-1:0]  ip_res;
  logic [bvfg_pkg::IW-1:0]         hi, sat_v;

  assign take      = op_i == bvfg_pkg::OP_TAKE;
  assign is_sample = bvfg_pkg::cmd_e'(item_i.cmd) == bvfg_pkg::CMD_SAMPLE;

  // clamped counts
  assign ncur = (ccnt_q == '0) ? bvfg_pkg::CCNT_W'(1) :
                (ccnt_q > bvfg_pkg::CCNT_W'(bvfg_pkg::MAX_CURVES)) ?
                bvfg_pkg::CCNT_W'(bvfg_pkg::MAX_CURVES) : ccnt_q;
  assign npts = (ppc_q == '0) ? bvfg_pkg::PPC_W'(1) :
                (ppc_q > bvfg_pkg::PPC_W'(bvfg_pkg::MAX_POINTS)) ?
                bvfg_pkg::PPC_W'(bvfg_pkg::MAX_POINTS) : ppc_q;
  assign ncur_m1 = ncur - bvfg_pkg::CCNT_W'(1);
  assign npts_m1 = npts - bvfg_pkg::PPC_W'(1);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cxl_q  <= bvfg_pkg::V_W'(3500000);
      cyl_q  <= bvfg_pkg::V_W'(3500000);
      cxh_q  <= bvfg_pkg::V_W'(4000000);
      cyh_q  <= bvfg_pkg::V_W'(4000000);
      load_q <= bvfg_pkg::LOAD_W'(350);
      ccnt_q <= bvfg_pkg::CCNT_W'(1);
      ppc_q  <= bvfg_pkg::PPC_W'(1);
    end else if (cfg_we_i) begin
      unique case (bvfg_pkg::cfg_reg_e'(cfg_idx_i))
        bvfg_pkg::REG_CORR_X_LOW:  cxl_q  <= cfg_data_i[bvfg_pkg::V_W-1:0];
        bvfg_pkg::REG_CORR_Y_LOW:  cyl_q  <= cfg_data_i[bvfg_pkg::V_W-1:0];
        bvfg_pkg::REG_CORR_X_HIGH: cxh_q  <= cfg_data_i[bvfg_pkg::V_W-1:0];
        bvfg_pkg::REG_CORR_Y_HIGH: cyh_q  <= cfg_data_i[bvfg_pkg::V_W-1:0];
        bvfg_pkg::REG_LOAD_CUR:    load_q <= cfg_data_i[bvfg_pkg::LOAD_W-1:0];
        bvfg_pkg::REG_CURVE_CNT:   ccnt_q <= cfg_data_i[bvfg_pkg::CCNT_W-1:0];
        bvfg_pkg::REG_POINTS:      ppc_q  <= cfg_data_i[bvfg_pkg::PPC_W-1:0];
        default: ;
      endcase
    end
  end

  // running sum over the ring
  assign wp_last = wp_q == bvfg_pkg::WP_W'(bvfg_pkg::AVG_DEPTH - 1);
  assign sum_new = sum_q + bvfg_pkg::SUM_W'(item_i.sample_uv)
                 - (wrapped_q ? bvfg_pkg::SUM_W'(ring_q[wp_q]) : '0);
  assign cnt     = wrapped_q ? bvfg_pkg::CNT_W'(bvfg_pkg::AVG_DEPTH)
                             : bvfg_pkg::CNT_W'(wp_q);

  always_ff @(posedge clk_i) begin
    if (take && is_sample) begin
      ring_q[wp_q] <= item_i.sample_uv;
    end
  end

  // table ports
  assign ld_we    = take && bvfg_pkg::cmd_e'(item_i.cmd) == bvfg_pkg::CMD_WR_LOAD
                    && 32'(item_i.curve_index) < bvfg_pkg::MAX_CURVES;
  assign pt_we    = take && bvfg_pkg::cmd_e'(item_i.cmd) == bvfg_pkg::CMD_WR_POINT
                    && 32'(item_i.curve_index) < bvfg_pkg::MAX_CURVES
                    && 32'(item_i.point_index) < bvfg_pkg::MAX_POINTS;
  assign ld_addr  = take ? item_i.curve_index[bvfg_pkg::CS_W-1:0] : cidx_q;
  assign ck       = pass_q ? k2_q : k1_q;
  assign pt_waddr = bvfg_pkg::PT_AW'(item_i.curve_index)
                    * bvfg_pkg::PT_AW'(bvfg_pkg::MAX_POINTS)
                    + bvfg_pkg::PT_AW'(item_i.point_index);
  assign pt_raddr = bvfg_pkg::PT_AW'(ck) * bvfg_pkg::PT_AW'(bvfg_pkg::MAX_POINTS)
                    + bvfg_pkg::PT_AW'(pidx_q);
  assign pt_addr  = take ? pt_waddr : pt_raddr;

  bvfg_ram #(.W(bvfg_pkg::LOAD_W), .D(bvfg_pkg::MAX_CURVES)) u_load_ram (
    .clk_i   (clk_i),
    .we_i    (ld_we),
    .addr_i  (ld_addr),
    .wdata_i (item_i.curve_load),
    .rdata_o (ld_rd)
  );

  bvfg_ram #(.W(bvfg_pkg::PT_DW), .D(bvfg_pkg::MAX_CURVES * bvfg_pkg::MAX_POINTS))
    u_point_ram (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .addr_i  (pt_addr),
    .wdata_i ({item_i.point_voltage_uv, item_i.point_capacity, item_i.point_time_s}),
    .rdata_o (pt_rd)
  );

  // scan compares
  assign ld       = ld_rd;
  assign cs_found = load_q > ld;
  assign cs_last  = bvfg_pkg::CCNT_W'(cidx_q) == ncur_m1;
  assign pv       = pt_rd[bvfg_pkg::PT_DW-1 -: bvfg_pkg::V_W];
  assign pval     = want_q ? pt_rd[bvfg_pkg::TIME_W-1:0]
                           : bvfg_pkg::TIME_W'(pt_rd[bvfg_pkg::TIME_W +: bvfg_pkg::PCT_W]);
  assign ps_found = v_q > pv;
  assign ps_last  = bvfg_pkg::PPC_W'(pidx_q) == npts_m1;

  // interpolation operands
  always_comb begin
    args = '0;
    case (op_i)
      bvfg_pkg::OP_AVG_GO: begin
        args.x0 = sum_q;
        args.x2 = bvfg_pkg::IW'(cnt);
        args.y2 = bvfg_pkg::IW'(1);
      end
      bvfg_pkg::OP_COR_GO: begin
        args = {bvfg_pkg::IW'(avg_q), bvfg_pkg::IW'(cxl_q), bvfg_pkg::IW'(cyl_q),
                bvfg_pkg::IW'(cxh_q), bvfg_pkg::IW'(cyh_q)};
      end
      bvfg_pkg::OP_PE_GO: begin
        args = {bvfg_pkg::IW'(v_q), bvfg_pkg::IW'(v1_q), bvfg_pkg::IW'(c1_q),
                bvfg_pkg::IW'(v2_q), bvfg_pkg::IW'(c2_q)};
      end
      default: begin
        args = {bvfg_pkg::IW'(load_q), bvfg_pkg::IW'(l1_q), bvfg_pkg::IW'(r1_q),
                bvfg_pkg::IW'(l2_q), bvfg_pkg::IW'(r2_q)};
      end
    endcase
  end

  assign ip_start = op_i == bvfg_pkg::OP_AVG_GO || op_i == bvfg_pkg::OP_COR_GO
                 || op_i == bvfg_pkg::OP_PE_GO  || op_i == bvfg_pkg::OP_FI_GO;

  bvfg_interp u_interp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ip_start),
    .args_i  (args),
    .done_o  (ip_done),
    .res_o   (ip_res)
  );

  assign hi    = want_q ? bvfg_pkg::IW'(bvfg_pkg::TIME_MAX) : bvfg_pkg::IW'(bvfg_pkg::PCT_MAX);
  assign sat_v = bvfg_pkg::sat_res(ip_res, hi);

  // control state
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      sum_q       <= '0;
      held_pct_q  <= '0;
      held_time_q <= '0;
      changed_q   <= 1'b0;
      want_q      <= 1'b0;
      pass_q      <= 1'b0;
      cidx_q      <= '0;
      pidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (op_i == bvfg_pkg::OP_OUT) || (out_valid_q && !out_ready_i);
      case (op_i)
        bvfg_pkg::OP_TAKE: begin
          changed_q <= 1'b0;
          want_q    <= 1'b0;
          if (is_sample) begin
            sum_q <= sum_new;
            wp_q  <= wp_last ? '0 : wp_q + 1'b1;
            if (wp_last) wrapped_q <= 1'b1;
          end else if (bvfg_pkg::cmd_e'(item_i.cmd) == bvfg_pkg::CMD_RST_AVG) begin
            sum_q     <= '0;
            wp_q      <= '0;
            wrapped_q <= 1'b0;
          end
        end
        bvfg_pkg::OP_EST_INIT: begin
          cidx_q <= '0;
          pass_q <= 1'b0;
        end
        bvfg_pkg::OP_CS_CMP: if (!cs_found && !cs_last) cidx_q <= cidx_q + 1'b1;
        bvfg_pkg::OP_PS_INIT: pidx_q <= '0;
        bvfg_pkg::OP_PS_CMP: if (!ps_found && !ps_last) pidx_q <= pidx_q + 1'b1;
        bvfg_pkg::OP_PE_END: pass_q <= 1'b1;
        bvfg_pkg::OP_HOLD_PCT: begin
          held_pct_q <= est_q[bvfg_pkg::PCT_W-1:0];
          changed_q  <= 1'b1;
          want_q     <= 1'b1;
        end
        bvfg_pkg::OP_HOLD_TIME: held_time_q <= est_q;
        default: ;
      endcase
    end
  end

  // data registers
  always_ff @(posedge clk_i) begin
    case (op_i)
      bvfg_pkg::OP_AVG_END: avg_q <= bvfg_pkg::V_W'(ip_res);
      bvfg_pkg::OP_COR_END:
        v_q <= bvfg_pkg::V_W'(bvfg_pkg::sat_res(ip_res, bvfg_pkg::IW'(bvfg_pkg::VMAX)));
      bvfg_pkg::OP_CS_CMP: begin
        if (cs_found) begin
          k1_q <= cidx_q;
          l1_q <= ld;
          k2_q <= (cidx_q == '0) ? cidx_q : cidx_q - 1'b1;
          l2_q <= (cidx_q == '0) ? ld : prevl_q;
        end else if (cs_last) begin
          k1_q <= cidx_q;
          k2_q <= cidx_q;
          l1_q <= ld;
          l2_q <= ld;
        end else begin
          prevl_q <= ld;
        end
      end
      bvfg_pkg::OP_PS_CMP: begin
        if (ps_found) begin
          v1_q <= pv;
          c1_q <= pval;
          v2_q <= (pidx_q == '0) ? pv : prevv_q;
          c2_q <= (pidx_q == '0) ? pval : prevc_q;
        end else if (ps_last) begin
          v1_q <= pv;
          c1_q <= pval;
          v2_q <= pv;
          c2_q <= pval;
        end else begin
          prevv_q <= pv;
          prevc_q <= pval;
        end
      end
      bvfg_pkg::OP_PE_END: begin
        r2_q <= bvfg_pkg::TIME_W'(sat_v);
        if (!pass_q) r1_q <= bvfg_pkg::TIME_W'(sat_v);
      end
      bvfg_pkg::OP_FI_END: est_q <= bvfg_pkg::TIME_W'(sat_v);
      bvfg_pkg::OP_OUT: begin
        out_q.capacity_percent <= held_pct_q;
        out_q.remaining_time_s <= held_time_q;
        out_q.estimate_changed <= changed_q;
        out_q.window_full      <= wrapped_q;
      end
      default: ;
    endcase
  end

  // status to the controller
  assign st_o.is_sample   = is_sample;
  assign st_o.ar_done     = ip_done;
  assign st_o.cs_stop     = cs_found || cs_last;
  assign st_o.ps_stop     = ps_found || ps_last;
  assign st_o.more_curves = !pass_q && (k1_q != k2_q);
  assign st_o.want_time   = want_q;
  assign st_o.pct_differs = est_q[bvfg_pkg::PCT_W-1:0] != held_pct_q;
  assign st_o.out_free    = out_free;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_pct_q <= bvfg_pkg::PCT_W'(bvfg_pkg::PCT_MAX))
    else $error("held percent out of range");
  a_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && is_sample && wp_last) |=> wrapped_q)
    else $error("ring wrap not flagged");
  a_out_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == bvfg_pkg::OP_OUT) |-> out_free)
    else $error("result loaded over an untaken transfer");
endmodule

/* hdl/bvfg_ctrl.sv */
// ----------------------------------------------------------------------------
// bvfg_ctrl
// Controller: sequences averaging, correction, curve and point scans and the
// interpolations, one item at a time.
// ----------------------------------------------------------------------------
module bvfg_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  bvfg_pkg::dp_status_t  st_i,
  output bvfg_pkg::dp_op_e      op_o
);
  bvfg_pkg::ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bvfg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    op_o       = bvfg_pkg::OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      bvfg_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_o    = bvfg_pkg::OP_TAKE;
          state_d = st_i.is_sample ? bvfg_pkg::ST_AVG_GO : bvfg_pkg::ST_DONE;
        end
      end
      bvfg_pkg::ST_AVG_GO: begin
        op_o    = bvfg_pkg::OP_AVG_GO;
        state_d = bvfg_pkg::ST_AVG_WT;
      end
      bvfg_pkg::ST_AVG_WT: if (st_i.ar_done) begin
        op_o    = bvfg_pkg::OP_AVG_END;
        state_d = bvfg_pkg::ST_COR_GO;
      end
      bvfg_pkg::ST_COR_GO: begin
        op_o    = bvfg_pkg::OP_COR_GO;
        state_d = bvfg_pkg::ST_COR_WT;
      end
      bvfg_pkg::ST_COR_WT: if (st_i.ar_done) begin
        op_o    = bvfg_pkg::OP_COR_END;
        state_d = bvfg_pkg::ST_EST;
      end
      bvfg_pkg::ST_EST: begin
        op_o    = bvfg_pkg::OP_EST_INIT;
        state_d = bvfg_pkg::ST_CS_RD;
      end
      bvfg_pkg::ST_CS_RD: begin
        op_o    = bvfg_pkg::OP_CS_RD;
        state_d = bvfg_pkg::ST_CS_CMP;
      end
      bvfg_pkg::ST_CS_CMP: begin
        op_o    = bvfg_pkg::OP_CS_CMP;
        state_d = st_i.cs_stop ? bvfg_pkg::ST_PS_INIT : bvfg_pkg::ST_CS_RD;
      end
      bvfg_pkg::ST_PS_INIT: begin
        op_o    = bvfg_pkg::OP_PS_INIT;
        state_d = bvfg_pkg::ST_PS_RD;
      end
      bvfg_pkg::ST_PS_RD: begin
        op_o    = bvfg_pkg::OP_PS_RD;
        state_d = bvfg_pkg::ST_PS_CMP;
      end
      bvfg_pkg::ST_PS_CMP: begin
        op_o    = bvfg_pkg::OP_PS_CMP;
        state_d = st_i.ps_stop ? bvfg_pkg::ST_PE_GO : bvfg_pkg::ST_PS_RD;
      end
      bvfg_pkg::ST_PE_GO: begin
        op_o    = bvfg_pkg::OP_PE_GO;
        state_d = bvfg_pkg::ST_PE_WT;
      end
      bvfg_pkg::ST_PE_WT: if (st_i.ar_done) begin
        op_o    = bvfg_pkg::OP_PE_END;
        state_d = st_i.more_curves ? bvfg_pkg::ST_PS_INIT : bvfg_pkg::ST_FI_GO;
      end
      bvfg_pkg::ST_FI_GO: begin
        op_o    = bvfg_pkg::OP_FI_GO;
        state_d = bvfg_pkg::ST_FI_WT;
      end
      bvfg_pkg::ST_FI_WT: if (st_i.ar_done) begin
        op_o    = bvfg_pkg::OP_FI_END;
        state_d = bvfg_pkg::ST_CHK;
      end
      bvfg_pkg::ST_CHK: begin
        if (st_i.want_time) begin
          op_o    = bvfg_pkg::OP_HOLD_TIME;
          state_d = bvfg_pkg::ST_DONE;
        end else if (st_i.pct_differs) begin
          op_o    = bvfg_pkg::OP_HOLD_PCT;
          state_d = bvfg_pkg::ST_EST;
        end else begin
          state_d = bvfg_pkg::ST_DONE;
        end
      end
      bvfg_pkg::ST_DONE: if (st_i.out_free) begin
        op_o    = bvfg_pkg::OP_OUT;
        state_d = bvfg_pkg::ST_IDLE;
      end
      default: state_d = bvfg_pkg::ST_IDLE;
    endcase
  end
endmodule

/* hdl/battery_voltage_fuel_gauge.sv */
// ----------------------------------------------------------------------------
// battery_voltage_fuel_gauge
// Voltage-lookup fuel gauge: averages samples, corrects them and interpolates
// capacity percent and remaining time from configured discharge curves.
// ----------------------------------------------------------------------------
// One item is handled at a time. A table write or average reset goes from the
// take straight to the done state, which loads the output register once it
// is free. A sample runs four to eight passes through the shared interpolation
// unit (averaging, correction, one or two curves, the load blend, and the
// curves and blend again for time when the percent changes), each through its
// one-bit-per-cycle 52-bit divide, plus a read and a compare state per curve
// and per point scanned in the table RAMs. A new item is taken while the
// previous result still waits in the output register; its result then waits
// until that register is free.
module battery_voltage_fuel_gauge (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bvfg_in_if.sink                     in_i,
  bvfg_out_if.source                  out_o,
  input  logic                        cfg_we_i,
  input  logic [bvfg_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [bvfg_pkg::CFG_DW-1:0] cfg_data_i
);
  bvfg_pkg::dp_op_e     op;
  bvfg_pkg::dp_status_t st;
  bvfg_pkg::in_item_t   item;
  bvfg_pkg::out_item_t  res;
  logic                 in_ready, out_valid;

  // gather the input payload
  assign item = {in_i.cmd, in_i.sample_uv, in_i.curve_index, in_i.point_index,
                 in_i.point_voltage_uv, in_i.point_capacity, in_i.point_time_s,
                 in_i.curve_load};

  bvfg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .st_i       (st),
    .op_o       (op)
  );

  bvfg_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .item_i      (item),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .out_item_o  (res),
    .st_o        (st)
  );

  // channel outputs
  assign in_i.ready             = in_ready;
  assign out_o.valid            = out_valid;
  assign out_o.capacity_percent = res.capacity_percent;
  assign out_o.remaining_time_s = res.remaining_time_s;
  assign out_o.estimate_changed = res.estimate_changed;
  assign out_o.window_full      = res.window_full;
endmodule
